>>> sv/tlge_pkg.sv
// shared types, widths and command codes of the toroidal life grid engine
package tlge_pkg;

	localparam int MAX_SIZE = 64;
	localparam int ROW_W = $clog2(MAX_SIZE);
	localparam int NW = $clog2(MAX_SIZE + 1);
	localparam int SIZE_W = 7;
	localparam int COORD_W = 6;
	localparam int FUNC_W = 2;
	localparam logic [SIZE_W-1:0] GRID_SIZE_RESET = SIZE_W'(64);

	localparam int CMD_DEPTH = 2;
	localparam int RES_DEPTH = 2;

	localparam logic [FUNC_W-1:0] FUNC_TOGGLE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_READ = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic in_grid;
	} cmd_t;

	typedef struct packed {
		logic cell_alive;
		logic out_of_range;
	} res_t;

endpackage

>>> sv/tlge_front.sv
// command front end: range check of the coordinate and a short command queue
module tlge_front (
	input  logic clk,
	input  logic arst_n,
	input  logic [tlge_pkg::NW-1:0] n,
	input  logic push,
	input  logic [tlge_pkg::FUNC_W-1:0] func,
	input  logic [tlge_pkg::COORD_W-1:0] col,
	input  logic [tlge_pkg::COORD_W-1:0] row,
	output logic full,
	output logic cmd_valid,
	output tlge_pkg::cmd_t cmd,
	input  logic cmd_ready
);

	localparam int PW = (tlge_pkg::CMD_DEPTH > 1) ? $clog2(tlge_pkg::CMD_DEPTH) : 1;
	localparam int CW = $clog2(tlge_pkg::CMD_DEPTH + 1);

	tlge_pkg::cmd_t entry_q [tlge_pkg::CMD_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic accept, deq;
	tlge_pkg::cmd_t cmd_in;

	assign full = (cnt_q == CW'(tlge_pkg::CMD_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd = entry_q[rd_ptr_q];
	assign accept = push && !full;
	assign deq = cmd_valid && cmd_ready;

	always_comb begin
		cmd_in.func = func;
		cmd_in.col = col;
		cmd_in.row = row;
		cmd_in.in_grid = (32'(col) < 32'(n)) && (32'(row) < 32'(n));
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= (wr_ptr_q == PW'(tlge_pkg::CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= (rd_ptr_q == PW'(tlge_pkg::CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({accept, deq})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> sv/tlge_back.sv
// command back end: row memory of the grid and the sequencer that runs each command
module tlge_back (
	input  logic clk,
	input  logic arst_n,
	input  logic [tlge_pkg::NW-1:0] n,
	input  logic cmd_valid,
	input  tlge_pkg::cmd_t cmd,
	output logic cmd_ready,
	input  logic res_space,
	output logic res_push,
	output tlge_pkg::res_t res
);

	localparam int MS = tlge_pkg::MAX_SIZE;
	localparam int RW = tlge_pkg::ROW_W;
	localparam int KW = $clog2(MS + 3);
	localparam logic [3:0] BIRTH = 4'd3;
	localparam logic [3:0] SURVIVE = 4'd2;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SWEEP = 2'd1;
	localparam logic [1:0] ST_RD = 2'd2;
	localparam logic [1:0] ST_RESP = 2'd3;

	// next state of one row from the rows above, at and below it
	function automatic logic [MS-1:0] life_row(input logic [MS-1:0] up, input logic [MS-1:0] mid,
			input logic [MS-1:0] dn, input logic [tlge_pkg::NW-1:0] sz);
		logic [MS-1:0] ul, ml, dl, urs, mrs, drs, nxt;
		logic [RW-1:0] last;
		logic at_last;
		logic [3:0] sum;
		last = RW'(sz - 1'b1);
		ul = {up[MS-2:0], up[last]};
		ml = {mid[MS-2:0], mid[last]};
		dl = {dn[MS-2:0], dn[last]};
		urs = {up[0], up[MS-1:1]};
		mrs = {mid[0], mid[MS-1:1]};
		drs = {dn[0], dn[MS-1:1]};
		for (int c = 0; c < MS; c++) begin
			at_last = (RW'(c) == last);
			sum = 4'(ul[c]) + 4'(up[c]) + 4'(at_last ? up[0] : urs[c])
				+ 4'(ml[c]) + 4'(at_last ? mid[0] : mrs[c])
				+ 4'(dl[c]) + 4'(dn[c]) + 4'(at_last ? dn[0] : drs[c]);
			if (32'(c) < 32'(sz)) begin
				nxt[c] = (sum == BIRTH) || (mid[c] && (sum == SURVIVE));
			end else begin
				nxt[c] = mid[c];
			end
		end
		return nxt;
	endfunction

	logic [1:0] state_q, state_d;
	tlge_pkg::cmd_t cmd_q;
	logic [KW-1:0] k_q;
	logic [MS-1:0] w0_q, w1_q, first_q;
	logic [MS-1:0] mem [MS];
	logic [MS-1:0] row_valid_q;
	logic [MS-1:0] rd_data_s1;
	logic rd_valid_s1;

	logic rd_en, wr_en, clr_all;
	logic [RW-1:0] rd_addr, wr_addr;
	logic [MS-1:0] wr_data, rd_row;
	logic [KW-1:0] n_k;
	logic take, cell_bit, new_bit, is_toggle;

	assign rd_row = rd_valid_s1 ? rd_data_s1 : '0;
	assign n_k = KW'(n);
	assign cmd_ready = (state_q == ST_IDLE) && res_space;
	assign take = cmd_valid && cmd_ready;
	assign is_toggle = (cmd_q.func == tlge_pkg::FUNC_TOGGLE);
	assign cell_bit = rd_row[RW'(cmd_q.col)];
	assign new_bit = cell_bit ^ is_toggle;

	always_comb begin
		state_d = state_q;
		rd_en = 1'b0;
		rd_addr = RW'(cmd_q.row);
		wr_en = 1'b0;
		wr_addr = RW'(cmd_q.row);
		wr_data = rd_row;
		clr_all = 1'b0;
		res_push = 1'b0;
		res.cell_alive = cmd_q.in_grid && new_bit;
		res.out_of_range = !cmd_q.in_grid;
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					case (cmd.func)
						tlge_pkg::FUNC_CLEAR: begin
							clr_all = 1'b1;
							state_d = ST_RD;
						end
						tlge_pkg::FUNC_ADVANCE: begin
							state_d = (n == '0) ? ST_RD : ST_SWEEP;
						end
						default: state_d = ST_RD;
					endcase
				end
			end
			ST_SWEEP: begin
				// reads go row n-1, then 0 up to n-1; writes trail the reads, a row is written once the next row has been read
				if (k_q <= n_k) begin
					rd_en = 1'b1;
					rd_addr = (k_q == '0) ? RW'(n - 1'b1) : RW'(k_q - 1'b1);
				end
				if ((k_q >= KW'(3)) && (k_q <= n_k + 1'b1)) begin
					wr_en = 1'b1;
					wr_addr = RW'(k_q - KW'(3));
					wr_data = life_row(w0_q, w1_q, rd_row, n);
				end
				if (k_q == n_k + KW'(2)) begin
					// last row wraps down onto the saved original row 0
					wr_en = 1'b1;
					wr_addr = RW'(n - 1'b1);
					wr_data = life_row(w0_q, w1_q, first_q, n);
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				rd_en = 1'b1;
				state_d = ST_RESP;
			end
			ST_RESP: begin
				res_push = 1'b1;
				if (is_toggle && cmd_q.in_grid) begin
					wr_en = 1'b1;
					wr_data = rd_row;
					wr_data[RW'(cmd_q.col)] = new_bit;
				end
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
		if (take) begin
			cmd_q <= cmd;
		end
		if (state_q == ST_SWEEP) begin
			if ((k_q >= KW'(1)) && (k_q <= n_k + 1'b1)) begin
				w0_q <= w1_q;
				w1_q <= rd_row;
			end
			if (k_q == KW'(2)) begin
				first_q <= rd_row;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q <= '0;
			row_valid_q <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SWEEP) begin
				k_q <= k_q + 1'b1;
			end else begin
				k_q <= '0;
			end
			if (clr_all) begin
				row_valid_q <= '0;
			end else if (wr_en) begin
				row_valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_s1 <= row_valid_q[rd_addr];
			end
		end
	end

endmodule

>>> sv/tlge_out.sv
// result queue between the back end and the result ports
module tlge_out (
	input  logic clk,
	input  logic arst_n,
	input  logic res_push,
	input  tlge_pkg::res_t res,
	output logic res_space,
	output logic empty,
	input  logic pop,
	output logic cell_alive,
	output logic out_of_range
);

	localparam int PW = (tlge_pkg::RES_DEPTH > 1) ? $clog2(tlge_pkg::RES_DEPTH) : 1;
	localparam int CW = $clog2(tlge_pkg::RES_DEPTH + 1);

	tlge_pkg::res_t entry_q [tlge_pkg::RES_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic deq;
	tlge_pkg::res_t head;

	assign res_space = (cnt_q != CW'(tlge_pkg::RES_DEPTH));
	assign empty = (cnt_q == '0);
	assign deq = pop && !empty;
	assign head = entry_q[rd_ptr_q];
	assign cell_alive = head.cell_alive;
	assign out_of_range = head.out_of_range;

	always_ff @(posedge clk) begin
		if (res_push) begin
			entry_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (res_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(tlge_pkg::RES_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= (rd_ptr_q == PW'(tlge_pkg::RES_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({res_push, deq})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> sv/toroidal_life_grid_engine.sv
// Toroidal life grid engine: commands go in through a two-deep command queue and every
// command returns one result through a two-deep result queue, in command order. Toggle, read
// and clear each pass through the back end's read and response states; clear drops the
// per-row valid bits at once. Advance on a grid edge n above zero first sweeps: the row memory
// has one read port and the sweep reads one row per cycle, the wrap-around row n-1 first, and
// the final row wraps onto the saved row 0. The grid is dead after reset with no clearing pass.
// grid_size above 64 acts as 64; a coordinate not below the size in effect flags
// out_of_range and reads as dead.
module toroidal_life_grid_engine (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic [tlge_pkg::FUNC_W-1:0] func,
	input  logic [tlge_pkg::COORD_W-1:0] col,
	input  logic [tlge_pkg::COORD_W-1:0] row,
	output logic empty,
	input  logic pop,
	output logic cell_alive,
	output logic out_of_range,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [tlge_pkg::SIZE_W-1:0] grid_size
);

	logic [tlge_pkg::SIZE_W-1:0] grid_size_q;
	logic [tlge_pkg::NW-1:0] n;
	logic cmd_valid, cmd_ready, res_space, res_push;
	tlge_pkg::cmd_t cmd;
	tlge_pkg::res_t res;

	assign cfg_ready = 1'b1;
	assign n = (32'(grid_size_q) > 32'(tlge_pkg::MAX_SIZE)) ?
		tlge_pkg::NW'(tlge_pkg::MAX_SIZE) : tlge_pkg::NW'(grid_size_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= tlge_pkg::GRID_SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			grid_size_q <= grid_size;
		end
	end

	tlge_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.n(n),
		.push(push),
		.func(func),
		.col(col),
		.row(row),
		.full(full),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_ready(cmd_ready)
	);

	tlge_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.n(n),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_ready(cmd_ready),
		.res_space(res_space),
		.res_push(res_push),
		.res(res)
	);

	tlge_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.res_push(res_push),
		.res(res),
		.res_space(res_space),
		.empty(empty),
		.pop(pop),
		.cell_alive(cell_alive),
		.out_of_range(out_of_range)
	);

endmodule

>>> sv/tlge_checker.sv
// port-level checks of the toroidal life grid engine and their bind
module tlge_checker (
	input logic clk,
	input logic arst_n,
	input logic full,
	input logic empty,
	input logic pop,
	input logic cell_alive,
	input logic out_of_range
);

	// the result queue is empty and the command queue not full once reset has been seen at an edge
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> (empty && !full))
		else $error("queues not empty after reset");

	// a cell outside the grid never reads as alive
	a_oor_dead: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_of_range) |-> !cell_alive)
		else $error("out of range result shows a live cell");

	// a waiting result is not lost
	a_res_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("waiting result vanished");

	// a waiting result keeps its value until the transaction completes
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> ($stable(cell_alive) && $stable(out_of_range)))
		else $error("waiting result changed");

endmodule

bind toroidal_life_grid_engine tlge_checker u_tlge_checker (.*);

>>> bench/toroidal_life_grid_engine_checker.sv
`timescale 1ns / 1ps
// checker that mirrors the life grid, predicts every command result and compares it
module toroidal_life_grid_engine_checker
	import tlge_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic full,
	input  logic [FUNC_W-1:0] func,
	input  logic [COORD_W-1:0] col,
	input  logic [COORD_W-1:0] row,
	input  logic empty,
	input  logic pop,
	input  logic cell_alive,
	input  logic out_of_range,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic [SIZE_W-1:0] grid_size,
	output int mismatches,
	output int pending
);

	bit [MAX_SIZE-1:0] cells [MAX_SIZE];
	logic [SIZE_W-1:0] size_reg = GRID_SIZE_RESET;
	res_t expected_cells [$];

	// one conway step over the n x n corner, wrapping at n
	function automatic void step_generation(int n);
		bit [MAX_SIZE-1:0] nxt [MAX_SIZE];
		int up, dn, lf, rt, sum;
		nxt = cells;
		for (int r = 0; r < n; r++) begin
			up = (r + n - 1) % n;
			dn = (r + 1) % n;
			for (int c = 0; c < n; c++) begin
				lf = (c + n - 1) % n;
				rt = (c + 1) % n;
				sum = cells[up][lf] + cells[up][c] + cells[up][rt] +
					cells[r][lf] + cells[r][rt] +
					cells[dn][lf] + cells[dn][c] + cells[dn][rt];
				nxt[r][c] = cells[r][c] ? (sum == 2 || sum == 3) : (sum == 3);
			end
		end
		cells = nxt;
	endfunction

	function automatic res_t apply_command(logic [FUNC_W-1:0] f, logic [COORD_W-1:0] c,
			logic [COORD_W-1:0] r);
		int n;
		bit in_grid;
		res_t res;
		n = (size_reg > MAX_SIZE) ? MAX_SIZE : int'(size_reg);
		in_grid = (c < n) && (r < n);
		case (f)
			FUNC_TOGGLE: begin
				if (in_grid)
					cells[r][c] = ~cells[r][c];
			end
			FUNC_CLEAR: begin
				foreach (cells[i])
					cells[i] = '0;
			end
			FUNC_ADVANCE: begin
				if (n > 0)
					step_generation(n);
			end
			default: ;
		endcase
		res.cell_alive = in_grid ? cells[r][c] : 1'b0;
		res.out_of_range = !in_grid;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		int errs;
		if (!arst_n) begin
			foreach (cells[i])
				cells[i] = '0;
			size_reg = GRID_SIZE_RESET;
			expected_cells.delete();
			mismatches <= 0;
			pending <= 0;
		end else begin
			errs = 0;
			// results leave the block registered, so a pop always matches an older command
			if (pop && !empty) begin
				if (expected_cells.size() == 0) begin
					$error("result transaction with no command waiting");
					errs++;
				end else begin
					want = expected_cells.pop_front();
					if (cell_alive !== want.cell_alive) begin
						$error("cell_alive mismatch: expected %0b, actual %0b",
							want.cell_alive, cell_alive);
						errs++;
					end
					if (out_of_range !== want.out_of_range) begin
						$error("out_of_range mismatch: expected %0b, actual %0b",
							want.out_of_range, out_of_range);
						errs++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				size_reg = grid_size;
			if (push && !full)
				expected_cells.push_back(apply_command(func, col, row));
			mismatches <= mismatches + errs;
			pending <= expected_cells.size();
		end
	end

endmodule

>>> bench/toroidal_life_grid_engine_test.sv
`timescale 1ns / 1ps
// testbench top: drives commands, grid size writes and result pops, and gives the verdict
module toroidal_life_grid_engine_test;
	import tlge_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 800;
	localparam int PHASE_SIZES [10] = '{2, 3, 64, 8, 65, 4, 16, 0, 1, 64};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic cfg_valid = 1'b0;
	logic [FUNC_W-1:0] func = FUNC_READ;
	logic [COORD_W-1:0] col = '0;
	logic [COORD_W-1:0] row = '0;
	logic [SIZE_W-1:0] grid_size = GRID_SIZE_RESET;
	logic full, empty, cell_alive, out_of_range, cfg_ready;
	int mismatches, pending;

	int idle_cycles = 0;
	int pop_wait = 0;
	bit pop_eager = 1'b0;
	bit push_eager = 1'b0;
	int cur_size = MAX_SIZE;
	int sent = 0;

	toroidal_life_grid_engine dut (.*);

	toroidal_life_grid_engine_checker u_checker (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int pause_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		else if (p < 85)
			return $urandom_range(1, 3);
		else if (p < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		int g;
		if (!arst_n) begin
			pop <= 1'b0;
			pop_wait <= 0;
		end else if (pop_wait > 0) begin
			pop_wait <= pop_wait - 1;
		end else if (pop && !empty) begin
			g = pop_eager ? 0 : pause_len();
			pop <= (g == 0);
			pop_wait <= g;
		end else begin
			pop <= 1'b1;
		end
	end

	task automatic send_cmd(logic [FUNC_W-1:0] f, int c, int r);
		push <= 1'b1;
		func <= f;
		col <= COORD_W'(c);
		row <= COORD_W'(r);
		do @(posedge clk); while (full);
		sent++;
	endtask

	task automatic hold_off(int n);
		if (n > 0) begin
			push <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		push <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_size(int v);
		drain();
		cfg_valid <= 1'b1;
		grid_size <= SIZE_W'(v);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_size = (v > MAX_SIZE) ? MAX_SIZE : v;
	endtask

	task automatic random_cmd();
		int p, c, r;
		logic [FUNC_W-1:0] f;
		p = $urandom_range(0, 99);
		if (p < 45)
			f = FUNC_TOGGLE;
		else if (p < 70)
			f = FUNC_READ;
		else if (p < 95)
			f = FUNC_ADVANCE;
		else
			f = FUNC_CLEAR;
		if (cur_size == 0 || $urandom_range(0, 9) == 0) begin
			c = $urandom_range(0, 63);
			r = $urandom_range(0, 63);
		end else begin
			c = $urandom_range(0, cur_size - 1);
			r = $urandom_range(0, cur_size - 1);
		end
		send_cmd(f, c, r);
		hold_off(push_eager ? 0 : pause_len());
	endtask

	initial begin
		int sz;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full size: corners, then a blinker that wraps across the column edge
		send_cmd(FUNC_READ, 0, 0);
		send_cmd(FUNC_READ, 63, 63);
		send_cmd(FUNC_TOGGLE, 63, 0);
		send_cmd(FUNC_TOGGLE, 0, 0);
		send_cmd(FUNC_TOGGLE, 1, 0);
		send_cmd(FUNC_ADVANCE, 0, 63);
		send_cmd(FUNC_READ, 0, 1);
		send_cmd(FUNC_READ, 63, 0);
		send_cmd(FUNC_ADVANCE, 63, 0);
		send_cmd(FUNC_TOGGLE, 0, 0);
		send_cmd(FUNC_CLEAR, 0, 0);

		// size above the maximum saturates
		write_size(127);
		send_cmd(FUNC_TOGGLE, 63, 63);
		send_cmd(FUNC_READ, 63, 63);

		// small grid: out of range toggle, advance and clear with a bad coordinate
		write_size(5);
		send_cmd(FUNC_TOGGLE, 5, 0);
		send_cmd(FUNC_TOGGLE, 4, 4);
		send_cmd(FUNC_READ, 63, 63);
		send_cmd(FUNC_ADVANCE, 42, 17);
		send_cmd(FUNC_CLEAR, 7, 7);

		// clear also wiped the cell outside the small grid
		write_size(64);
		send_cmd(FUNC_READ, 63, 63);

		// one cell grid counts itself as its neighbors, zero size ignores everything
		write_size(1);
		send_cmd(FUNC_TOGGLE, 0, 0);
		send_cmd(FUNC_ADVANCE, 0, 0);
		write_size(0);
		send_cmd(FUNC_TOGGLE, 0, 0);
		send_cmd(FUNC_ADVANCE, 0, 0);

		for (int ph = 0; sent < RANDOM_ITEMS + 25; ph++) begin
			if (ph < 10)
				sz = PHASE_SIZES[ph];
			else if ($urandom_range(0, 3) == 0)
				sz = 64;
			else
				sz = $urandom_range(3, 12);
			write_size(sz);
			push_eager = ($urandom_range(0, 3) == 0);
			pop_eager <= ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(30, 70)) random_cmd();
		end

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> files.f
sv/tlge_pkg.sv
sv/tlge_front.sv
sv/tlge_back.sv
sv/tlge_out.sv
sv/toroidal_life_grid_engine.sv
sv/tlge_checker.sv
bench/toroidal_life_grid_engine_checker.sv
bench/toroidal_life_grid_engine_test.sv
